// File: rtl/kbtj_pkg.sv
// Shared types, constants and helper functions for the known-bits ternary join block.
// Used by kbtj_div3 and known_bits_ternary_join; depends on nothing else.

package kbtj_pkg;

  // Field widths
  localparam int unsigned IdxW       = 26;
  localparam int unsigned MaskW      = 16;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned PowW       = 32;
  localparam int unsigned DefMaxBits = 16;
  localparam int unsigned ResetWidth = 8;

  // Divide by three: q = (v * Div3Mul) >> Div3Shift, exact for every IdxW-bit v
  localparam logic [IdxW-1:0] Div3Mul   = IdxW'(44739243);
  localparam int unsigned     Div3Shift = 27;

  // Ternary digit codes
  localparam logic [1:0] DigUnknown = 2'd0;
  localparam logic [1:0] DigZero    = 2'd1;
  localparam logic [1:0] DigOne     = 2'd2;

  typedef enum logic [1:0] {
    OP_JOIN   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2
  } kbtj_op_e;

  typedef struct packed {
    kbtj_op_e         op;
    logic [IdxW-1:0]  index_a;
    logic [IdxW-1:0]  index_b;
    logic [MaskW-1:0] zero_mask;
    logic [MaskW-1:0] one_mask;
  } kbtj_req_t;

  typedef struct packed {
    logic [IdxW-1:0]  result_index;
    logic [MaskW-1:0] known_zero;
    logic [MaskW-1:0] known_one;
    logic             status;
  } kbtj_rsp_t;

  // Three to the power n, for n up to nineteen
  function automatic logic [PowW-1:0] pow3(input logic [CfgW-1:0] n);
    logic [PowW-1:0] p;
    case (n)
      5'd0:    p = PowW'(1);
      5'd1:    p = PowW'(3);
      5'd2:    p = PowW'(9);
      5'd3:    p = PowW'(27);
      5'd4:    p = PowW'(81);
      5'd5:    p = PowW'(243);
      5'd6:    p = PowW'(729);
      5'd7:    p = PowW'(2187);
      5'd8:    p = PowW'(6561);
      5'd9:    p = PowW'(19683);
      5'd10:   p = PowW'(59049);
      5'd11:   p = PowW'(177147);
      5'd12:   p = PowW'(531441);
      5'd13:   p = PowW'(1594323);
      5'd14:   p = PowW'(4782969);
      5'd15:   p = PowW'(14348907);
      5'd16:   p = PowW'(43046721);
      5'd17:   p = PowW'(129140163);
      5'd18:   p = PowW'(387420489);
      default: p = PowW'(1162261467);
    endcase
    return p;
  endfunction

  // Force a written width into the range one to maxw
  function automatic logic [CfgW-1:0] clamp_width(input logic [CfgW-1:0] raw,
                                                  input logic [CfgW-1:0] maxw);
    logic [CfgW-1:0] w;
    if (raw == '0) begin
      w = CfgW'(1);
    end else if (raw > maxw) begin
      w = maxw;
    end else begin
      w = raw;
    end
    return w;
  endfunction

endpackage

// File: rtl/known_bits_ternary_join.sv
// Top level of the known-bits ternary join unit: pipelined join, encode and decode.
// Depends on kbtj_pkg and kbtj_div3.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------
//  cfg     | in        | cfg_we_i               | cfg_wdata_i (width)
//  in      | in        | in_valid_i / in_ready_o| in_req_i
//  out     | out       | out_valid_o/out_ready_i| out_rsp_o
//
// One request enters per cycle unless the pipeline freezes; stages: range check, decode
// (one ternary digit per stage), encode (one digit per stage), output register.
// Reset clears all valid bits and loads a width of eight (clamped to MAX_BITS).
// The pipeline freezes only when its last stage and the output register both hold
// results and the output is not taken; bubbles keep filling otherwise.

module known_bits_ternary_join #(
  parameter int unsigned MAX_BITS = kbtj_pkg::DefMaxBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kbtj_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kbtj_pkg::kbtj_req_t       in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kbtj_pkg::kbtj_rsp_t       out_rsp_o
);
  import kbtj_pkg::*;

  localparam logic [CfgW-1:0] MaxW   = CfgW'(MAX_BITS);
  localparam logic [CfgW-1:0] WReset = clamp_width(CfgW'(ResetWidth), MaxW);

  // Configuration: effective width and its limit
  logic [CfgW-1:0] w_q, w_d;
  logic [PowW-1:0] limit_q, limit_d;

  assign w_d     = clamp_width(cfg_wdata_i, MaxW);
  assign limit_d = pow3(w_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WReset;
      limit_q <= pow3(WReset);
    end else if (cfg_we_i) begin
      w_q     <= w_d;
      limit_q <= limit_d;
    end
  end

  // Pipeline advance
  logic en;
  logic out_v_q;
  logic e_v [MAX_BITS+1];

  assign en         = !e_v[MAX_BITS] || !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: capture the request and range-check the indices
  logic            s0_v_q;
  kbtj_op_e        s0_op_q;
  logic            s0_bad_q, s0_bad_d;
  logic [IdxW-1:0] s0_ia_q, s0_ib_q;
  logic [MaskW-1:0] s0_zm_q, s0_om_q;
  logic            a_bad, b_bad;

  assign a_bad = {{(PowW-IdxW){1'b0}}, in_req_i.index_a} >= limit_q;
  assign b_bad = {{(PowW-IdxW){1'b0}}, in_req_i.index_b} >= limit_q;

  always_comb begin
    case (in_req_i.op)
      OP_JOIN:   s0_bad_d = a_bad || b_bad;
      OP_DECODE: s0_bad_d = a_bad;
      default:   s0_bad_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_op_q  <= in_req_i.op;
      s0_bad_q <= s0_bad_d;
      s0_ia_q  <= in_req_i.index_a;
      s0_ib_q  <= in_req_i.index_b;
      s0_zm_q  <= in_req_i.zero_mask;
      s0_om_q  <= in_req_i.one_mask;
    end
  end

  // Decode stages: one ternary digit of each index per stage
  logic                d_v   [MAX_BITS+1];
  kbtj_op_e            d_op  [MAX_BITS+1];
  logic                d_bad [MAX_BITS+1];
  logic [IdxW-1:0]     d_va  [MAX_BITS+1];
  logic [IdxW-1:0]     d_vb  [MAX_BITS+1];
  logic [MAX_BITS-1:0] d_za  [MAX_BITS+1];
  logic [MAX_BITS-1:0] d_oa  [MAX_BITS+1];
  logic [MAX_BITS-1:0] d_zb  [MAX_BITS+1];
  logic [MAX_BITS-1:0] d_ob  [MAX_BITS+1];
  logic [MaskW-1:0]    d_zm  [MAX_BITS+1];
  logic [MaskW-1:0]    d_om  [MAX_BITS+1];

  assign d_v[0]   = s0_v_q;
  assign d_op[0]  = s0_op_q;
  assign d_bad[0] = s0_bad_q;
  assign d_va[0]  = s0_ia_q;
  assign d_vb[0]  = s0_ib_q;
  assign d_za[0]  = '0;
  assign d_oa[0]  = '0;
  assign d_zb[0]  = '0;
  assign d_ob[0]  = '0;
  assign d_zm[0]  = s0_zm_q;
  assign d_om[0]  = s0_om_q;

  for (genvar k = 0; k < MAX_BITS; k++) begin : g_dec
    logic [IdxW-1:0] qa, qb;
    logic [1:0]      da, db;
    logic            act;

    kbtj_div3 u_div_a (.value_i(d_va[k]), .quot_o(qa), .digit_o(da));
    kbtj_div3 u_div_b (.value_i(d_vb[k]), .quot_o(qb), .digit_o(db));

    assign act = w_q > CfgW'(k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v[k+1] <= 1'b0;
      end else if (en) begin
        d_v[k+1] <= d_v[k];
      end
    end

    // Shift each digit in at the bottom so the first one lands at bit w-1
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_op[k+1]  <= d_op[k];
        d_bad[k+1] <= d_bad[k];
        d_zm[k+1]  <= d_zm[k];
        d_om[k+1]  <= d_om[k];
        if (act) begin
          d_va[k+1] <= qa;
          d_vb[k+1] <= qb;
          d_za[k+1] <= (d_za[k] << 1) | MAX_BITS'(da == DigZero);
          d_oa[k+1] <= (d_oa[k] << 1) | MAX_BITS'(da == DigOne);
          d_zb[k+1] <= (d_zb[k] << 1) | MAX_BITS'(db == DigZero);
          d_ob[k+1] <= (d_ob[k] << 1) | MAX_BITS'(db == DigOne);
        end else begin
          d_va[k+1] <= d_va[k];
          d_vb[k+1] <= d_vb[k];
          d_za[k+1] <= d_za[k];
          d_oa[k+1] <= d_oa[k];
          d_zb[k+1] <= d_zb[k];
          d_ob[k+1] <= d_ob[k];
        end
      end
    end
  end

  // Encode stages: Horner step per bit, bit 0 first
  kbtj_op_e            e_op  [MAX_BITS+1];
  logic                e_bad [MAX_BITS+1];
  logic [MAX_BITS-1:0] e_z   [MAX_BITS+1];
  logic [MAX_BITS-1:0] e_o   [MAX_BITS+1];
  logic [MaskW-1:0]    e_kz  [MAX_BITS+1];
  logic [MaskW-1:0]    e_ko  [MAX_BITS+1];
  logic [IdxW-1:0]     e_r   [MAX_BITS+1];

  // Pick the masks to encode: joined masks or the request's own
  always_comb begin
    e_v[0]   = d_v[MAX_BITS];
    e_op[0]  = d_op[MAX_BITS];
    e_bad[0] = d_bad[MAX_BITS];
    e_kz[0]  = MaskW'(d_za[MAX_BITS]);
    e_ko[0]  = MaskW'(d_oa[MAX_BITS]);
    e_r[0]   = '0;
    if (d_op[MAX_BITS] == OP_ENCODE) begin
      e_z[0] = MAX_BITS'(d_zm[MAX_BITS]);
      e_o[0] = MAX_BITS'(d_om[MAX_BITS]);
    end else begin
      e_z[0] = d_za[MAX_BITS] & d_zb[MAX_BITS];
      e_o[0] = d_oa[MAX_BITS] & d_ob[MAX_BITS];
    end
  end

  for (genvar j = 0; j < MAX_BITS; j++) begin : g_enc
    logic [1:0] dig;
    logic       act;

    assign act = w_q > CfgW'(j);

    // Known zero wins over known one
    always_comb begin
      if (e_z[j][j]) begin
        dig = DigZero;
      end else if (e_o[j][j]) begin
        dig = DigOne;
      end else begin
        dig = DigUnknown;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        e_v[j+1] <= 1'b0;
      end else if (en) begin
        e_v[j+1] <= e_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_op[j+1]  <= e_op[j];
        e_bad[j+1] <= e_bad[j];
        e_z[j+1]   <= e_z[j];
        e_o[j+1]   <= e_o[j];
        e_kz[j+1]  <= e_kz[j];
        e_ko[j+1]  <= e_ko[j];
        if (act) begin
          e_r[j+1] <= (e_r[j] << 1) + e_r[j] + IdxW'(dig);
        end else begin
          e_r[j+1] <= e_r[j];
        end
      end
    end
  end

  // Form the response; bad indices give zero fields with status set, unused ops give all zeros
  kbtj_rsp_t rsp_d, rsp_q;

  always_comb begin
    rsp_d = '0;
    case (e_op[MAX_BITS])
      OP_JOIN: begin
        rsp_d.status = e_bad[MAX_BITS];
        if (!e_bad[MAX_BITS]) begin
          rsp_d.result_index = e_r[MAX_BITS];
        end
      end
      OP_ENCODE: begin
        rsp_d.result_index = e_r[MAX_BITS];
      end
      OP_DECODE: begin
        rsp_d.status = e_bad[MAX_BITS];
        if (!e_bad[MAX_BITS]) begin
          rsp_d.known_zero = e_kz[MAX_BITS];
          rsp_d.known_one  = e_ko[MAX_BITS];
        end
      end
      default: rsp_d = '0;
    endcase
  end

  // Output register: load from the last stage, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en && e_v[MAX_BITS]) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && e_v[MAX_BITS]) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = rsp_q;

endmodule

// File: rtl/kbtj_div3.sv
// Splits an index into its lowest ternary digit and the quotient by three.
// Depends on kbtj_pkg for widths and the reciprocal constant.

module kbtj_div3 (
  input  logic [kbtj_pkg::IdxW-1:0] value_i,
  output logic [kbtj_pkg::IdxW-1:0] quot_o,
  output logic [1:0]                digit_o
);
  import kbtj_pkg::*;

  logic [2*IdxW-1:0] prod;
  logic [IdxW-1:0]   back;

  // Multiply by the reciprocal and keep the top bits
  assign prod   = {{IdxW{1'b0}}, value_i} * {{IdxW{1'b0}}, Div3Mul};
  assign quot_o = IdxW'(prod >> Div3Shift);

  // Remainder is what the quotient leaves behind
  assign back    = (quot_o << 1) + quot_o;
  assign digit_o = 2'(value_i - back);

endmodule

// File: tb/tb.sv
// Self-checking testbench for known_bits_ternary_join: directed table, then random requests.
// Depends on kbtj_pkg and the known_bits_ternary_join RTL; reads nothing else.
`timescale 1ns / 100ps

module tb;
  import kbtj_pkg::*;

  localparam int unsigned TrackedMax = DefMaxBits;
  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam logic [IdxW-1:0] IdxTop = {IdxW{1'b1}};
  // Width-8 landmarks: three to the eighth, all digits known one, all digits known zero
  localparam logic [IdxW-1:0] Span8    = IdxW'(6561);
  localparam logic [IdxW-1:0] AllOne8  = IdxW'(6560);
  localparam logic [IdxW-1:0] AllZero8 = IdxW'(3280);
  localparam int unsigned SqueezeAt  = 190;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 9;

  typedef struct {
    kbtj_req_t req;
    bit        typed;
    kbtj_rsp_t rsp;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  kbtj_req_t           in_req_i;
  logic                out_valid_o;
  logic                out_ready_i;
  kbtj_rsp_t           out_rsp_o;

  // Typed expectation that travels with the request being offered
  bit                  hand_typed;
  kbtj_rsp_t           hand_rsp;

  kbtj_rsp_t           awaited_rsp[$];
  plan_row_t           plan[$];
  logic [CfgW-1:0]     width_shadow = CfgW'(ResetWidth);
  int unsigned         accepted_requests = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycles = 0;
  int                  burst_left = 0;

  known_bits_ternary_join #(
    .MAX_BITS(TrackedMax)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Predictor of the lattice unit

  function automatic int unsigned eff_bits(logic [CfgW-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > TrackedMax) begin
      return TrackedMax;
    end
    return 32'(raw);
  endfunction

  function automatic logic [31:0] ternary_span(int unsigned w);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < w; i++) p = p * 3;
    return p;
  endfunction

  // Bit 0 goes first, so it lands in the most significant digit
  function automatic logic [IdxW-1:0] pack_digits(int unsigned w, logic [MaskW-1:0] zm,
                                                  logic [MaskW-1:0] om);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < w; i++) begin
      acc = acc * 3 + (zm[i] ? 32'(DigZero) : (om[i] ? 32'(DigOne) : 32'(DigUnknown)));
    end
    return acc[IdxW-1:0];
  endfunction

  function automatic void unpack_digits(int unsigned w, logic [IdxW-1:0] idx,
                                        output logic [MaskW-1:0] zm,
                                        output logic [MaskW-1:0] om);
    logic [IdxW-1:0] rest;
    logic [1:0]      dig;
    rest = idx;
    zm = '0;
    om = '0;
    for (int k = 0; k < w; k++) begin
      dig = 2'(rest % 3);
      rest = IdxW'(rest / 3);
      if (dig == DigZero) begin
        zm[w-1-k] = 1'b1;
      end else if (dig == DigOne) begin
        om[w-1-k] = 1'b1;
      end
    end
  endfunction

  function automatic kbtj_rsp_t predict_lattice(kbtj_req_t req, logic [CfgW-1:0] raw);
    int unsigned      w;
    logic [31:0]      span;
    logic [MaskW-1:0] za, oa, zb, ob;
    kbtj_rsp_t        rsp;
    w = eff_bits(raw);
    span = ternary_span(w);
    rsp = '0;
    case (req.op)
      OP_JOIN: begin
        if (32'(req.index_a) >= span || 32'(req.index_b) >= span) begin
          rsp.status = 1'b1;
        end else begin
          unpack_digits(w, req.index_a, za, oa);
          unpack_digits(w, req.index_b, zb, ob);
          rsp.result_index = pack_digits(w, za & zb, oa & ob);
        end
      end
      OP_ENCODE: begin
        rsp.result_index = pack_digits(w, req.zero_mask, req.one_mask);
      end
      OP_DECODE: begin
        if (32'(req.index_a) >= span) begin
          rsp.status = 1'b1;
        end else begin
          unpack_digits(w, req.index_a, za, oa);
          rsp.known_zero = za;
          rsp.known_one  = oa;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Stimulus helpers

  function automatic void add_row(logic [1:0] op, logic [IdxW-1:0] ia, logic [IdxW-1:0] ib,
                                  logic [MaskW-1:0] zm, logic [MaskW-1:0] om, bit typed,
                                  logic [IdxW-1:0] res, logic [MaskW-1:0] kz,
                                  logic [MaskW-1:0] ko, logic st);
    plan_row_t r;
    r.req.op        = kbtj_op_e'(op);
    r.req.index_a   = ia;
    r.req.index_b   = ib;
    r.req.zero_mask = zm;
    r.req.one_mask  = om;
    r.typed               = typed;
    r.rsp.result_index    = res;
    r.rsp.known_zero      = kz;
    r.rsp.known_one       = ko;
    r.rsp.status          = st;
    plan = {plan, r};
  endfunction

  // Mostly in-range indices, with a share past the top of the range
  function automatic logic [IdxW-1:0] pick_index(logic [31:0] span);
    if ($urandom_range(0, 9) == 0) begin
      return IdxW'($urandom_range(span, 32'(IdxTop)));
    end
    return IdxW'($urandom_range(0, span - 1));
  endfunction

  function automatic kbtj_req_t random_request(logic [31:0] span);
    kbtj_req_t   req;
    int unsigned pick;
    logic [31:0] bits;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      req.op = OP_JOIN;
    end else if (pick < 64) begin
      req.op = OP_ENCODE;
    end else if (pick < 92) begin
      req.op = OP_DECODE;
    end else begin
      req.op = kbtj_op_e'(OpUnused);
    end
    req.index_a = pick_index(span);
    req.index_b = pick_index(span);
    bits = $urandom();
    req.zero_mask = bits[15:0];
    req.one_mask  = bits[31:16];
    // Half of the masks stay disjoint, as a well-formed encode would have them
    if ($urandom_range(0, 1) == 1) begin
      req.one_mask = req.one_mask & ~req.zero_mask;
    end
    return req;
  endfunction

  // Offer one request and hold it until it is taken
  task automatic drive_request(kbtj_req_t req, bit typed, kbtj_rsp_t rsp);
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    hand_typed <= typed;
    hand_rsp   <= rsp;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Keep the burst going, or drop valid for a random gap
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_width(logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Record accepted requests, check results, track the width register
  always @(posedge clk_i) begin : watch
    kbtj_rsp_t want;
    kbtj_rsp_t fresh;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accepted_requests++;
        fresh = hand_typed ? hand_rsp : predict_lattice(in_req_i, width_shadow);
        awaited_rsp = {awaited_rsp, fresh};
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result %p", $time, out_rsp_o);
        end else begin
          want = awaited_rsp[0];
          awaited_rsp.delete(0);
          if (out_rsp_o.result_index !== want.result_index) begin
            mismatches++;
            $display("%0t: result_index expected %0d actual %0d", $time,
                     want.result_index, out_rsp_o.result_index);
          end
          if (out_rsp_o.known_zero !== want.known_zero) begin
            mismatches++;
            $display("%0t: known_zero expected %h actual %h", $time,
                     want.known_zero, out_rsp_o.known_zero);
          end
          if (out_rsp_o.known_one !== want.known_one) begin
            mismatches++;
            $display("%0t: known_one expected %h actual %h", $time,
                     want.known_one, out_rsp_o.known_one);
          end
          if (out_rsp_o.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %b actual %b", $time,
                     want.status, out_rsp_o.status);
          end
        end
      end
      if (cfg_we_i) begin
        width_shadow = cfg_wdata_i;
      end
    end
  end

  // Receiver: stall in patterns of its own, and hold off once for a long stretch
  initial begin : receiver
    int  mode;
    int  span;
    bit  squeezed;
    squeezed    = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 48);
      repeat (span) begin
        if (!squeezed && accepted_requests >= SqueezeAt) begin
          squeezed = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk_i);
      end
    end
  end

  // Sender and run control
  initial begin : sender
    logic [CfgW-1:0] phase_width [NumPhases];
    int unsigned     phase_items [NumPhases];
    kbtj_rsp_t       none;
    phase_width = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd16, 5'd17, 5'd5, 5'd12, 5'd0};
    phase_items = '{40, 40, 40, 40, 90, 40, 40, 40, 40};
    phase_width[NumPhases-1] = CfgW'($urandom_range(3, 15));
    none = '0;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    hand_typed  = 1'b0;
    hand_rsp    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table at the reset width of eight
    add_row(OP_JOIN,   '0,       '0,       '0, '0, 1, '0,       '0, '0, 1'b0);
    add_row(OP_JOIN,   AllOne8,  AllOne8,  '0, '0, 1, AllOne8,  '0, '0, 1'b0);
    add_row(OP_JOIN,   AllOne8,  '0,       '0, '0, 1, '0,       '0, '0, 1'b0);
    add_row(OP_JOIN,   AllZero8, AllOne8,  '0, '0, 1, '0,       '0, '0, 1'b0);
    add_row(OP_JOIN,   AllZero8, AllZero8, '0, '0, 1, AllZero8, '0, '0, 1'b0);
    add_row(OP_JOIN,   Span8,    '0,       '0, '0, 1, '0,       '0, '0, 1'b1);
    add_row(OP_JOIN,   '0,       Span8,    '0, '0, 1, '0,       '0, '0, 1'b1);
    add_row(OP_JOIN,   IdxTop,   IdxTop,   '1, '1, 1, '0,       '0, '0, 1'b1);
    add_row(OP_JOIN,   26'd2187, 26'd4374, '0, '0, 0, '0,       '0, '0, 1'b0);
    add_row(OP_JOIN,   26'd1234, 26'd5678, '1, '0, 0, '0,       '0, '0, 1'b0);
    add_row(OP_ENCODE, '0,       '0,       '0, '0, 1, '0,       '0, '0, 1'b0);
    add_row(OP_ENCODE, IdxTop,   IdxTop,   16'h0000, 16'h00ff, 1, AllOne8,  '0, '0, 1'b0);
    add_row(OP_ENCODE, '0,       '0,       16'h00ff, 16'h00ff, 1, AllZero8, '0, '0, 1'b0);
    add_row(OP_ENCODE, '0,       '0,       16'hffff, 16'hffff, 1, AllZero8, '0, '0, 1'b0);
    add_row(OP_ENCODE, '0,       '0,       16'h0001, 16'h0000, 0, '0, '0, '0, 1'b0);
    add_row(OP_ENCODE, '0,       '0,       16'h00a5, 16'h005a, 0, '0, '0, '0, 1'b0);
    add_row(OP_ENCODE, '0,       '0,       16'hff00, 16'h00ff, 0, '0, '0, '0, 1'b0);
    add_row(OP_DECODE, '0,       IdxTop,   '1, '1, 1, '0, '0,       '0,       1'b0);
    add_row(OP_DECODE, AllOne8,  '0,       '0, '0, 1, '0, '0,       16'h00ff, 1'b0);
    add_row(OP_DECODE, AllZero8, '0,       '0, '0, 1, '0, 16'h00ff, '0,       1'b0);
    add_row(OP_DECODE, Span8,    '0,       '0, '0, 1, '0, '0,       '0,       1'b1);
    add_row(OP_DECODE, IdxTop,   '0,       '0, '0, 1, '0, '0,       '0,       1'b1);
    add_row(OP_DECODE, 26'd2187, '0,       '0, '0, 0, '0, '0,       '0,       1'b0);
    add_row(OpUnused,  IdxTop,   IdxTop,   '1, '1, 1, '0, '0,       '0,       1'b0);
    add_row(OpUnused,  '0,       '0,       '0, '0, 1, '0, '0,       '0,       1'b0);

    foreach (plan[i]) begin
      drive_request(plan[i].req, plan[i].typed, plan[i].rsp);
      pace();
    end
    drain();

    // Random phases, each at its own width
    for (int p = 0; p < NumPhases; p++) begin
      write_width(phase_width[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        drive_request(random_request(ternary_span(eff_bits(phase_width[p]))), 1'b0, none);
        pace();
      end
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (2 * TrackedMax + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: known_bits_ternary_join.f
rtl/kbtj_pkg.sv
rtl/kbtj_div3.sv
rtl/known_bits_ternary_join.sv
tb/tb.sv
